[hdl/met_pkg.sv]
// ----------------------------------------------------------------------------
// met_pkg
// shared types, register codes, reset values, saturation and palette
// ----------------------------------------------------------------------------
package met_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_MAX_ITERATIONS = 3'd0;
    localparam logic [2:0] REG_ORIGIN_REAL    = 3'd1;
    localparam logic [2:0] REG_ORIGIN_IMAG    = 3'd2;
    localparam logic [2:0] REG_STEP_REAL      = 3'd3;
    localparam logic [2:0] REG_STEP_IMAG      = 3'd4;

    // register reset values
    localparam logic [15:0]        RST_MAX_ITERATIONS = 16'd500;
    localparam logic signed [31:0] RST_ORIGIN_REAL    = 32'shE000_0000;
    localparam logic signed [31:0] RST_ORIGIN_IMAG    = 32'sh1000_0000;
    localparam logic [30:0]        RST_STEP_REAL      = 31'd786432;
    localparam logic [30:0]        RST_STEP_IMAG      = 31'd699051;

    // point in the complex plane, signed fixed point
    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } coord_t;

    // iteration engine states
    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_MULT,
        ENG_STEP,
        ENG_DONE
    } eng_state_t;

    // clamp a wide signed value to the 32-bit signed range
    function automatic logic signed [31:0] sat_coord(input logic signed [63:0] v);
        logic signed [31:0] r;
        if ((&v[63:31]) || !(|v[63:31])) begin
            r = v[31:0];
        end else if (v[63]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // 16-entry color table, {red, green, blue}
    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        logic [23:0] rgb;
        unique case (idx)
            4'd0:    rgb = 24'h421E0F;
            4'd1:    rgb = 24'h19071A;
            4'd2:    rgb = 24'h09012F;
            4'd3:    rgb = 24'h040449;
            4'd4:    rgb = 24'h000764;
            4'd5:    rgb = 24'h0C2C8A;
            4'd6:    rgb = 24'h1852B1;
            4'd7:    rgb = 24'h397DD1;
            4'd8:    rgb = 24'h86B5E5;
            4'd9:    rgb = 24'hD3ECF8;
            4'd10:   rgb = 24'hF1E9BF;
            4'd11:   rgb = 24'hF8C95F;
            4'd12:   rgb = 24'hFFAA00;
            4'd13:   rgb = 24'hCC8000;
            4'd14:   rgb = 24'h995700;
            default: rgb = 24'h6A3403;
        endcase
        return rgb;
    endfunction

endpackage

[hdl/met_front.sv]
// ----------------------------------------------------------------------------
// met_front
// accepts pixel transactions and maps (column, row) to a point c
// ----------------------------------------------------------------------------
module met_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [9:0]            s_pixel_col,
    input  logic [9:0]            s_pixel_row,
    input  logic signed [31:0]    origin_real,
    input  logic signed [31:0]    origin_imag,
    input  logic [30:0]           step_real,
    input  logic [30:0]           step_imag,
    output logic                  q_push,
    input  logic                  q_ready,
    output met_pkg::coord_t       q_data
);

    logic        v1_reg;
    logic [40:0] col_prod_reg;
    logic [40:0] row_prod_reg;
    logic [40:0] col_prod;
    logic [40:0] row_prod;
    logic        accept;
    logic signed [63:0] re_sum;
    logic signed [63:0] im_sum;

    // stage one: offsets from the origin
    assign col_prod = {31'd0, s_pixel_col} * {10'd0, step_real};
    assign row_prod = {31'd0, s_pixel_row} * {10'd0, step_imag};

    assign s_ready = !v1_reg || q_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_ready) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            col_prod_reg <= col_prod;
            row_prod_reg <= row_prod;
        end
    end

    // stage two: add the column offset to and subtract the row offset from the origin, clamp, hand to the queue
    assign re_sum = {{32{origin_real[31]}}, origin_real} + {23'd0, col_prod_reg};
    assign im_sum = {{32{origin_imag[31]}}, origin_imag} - {23'd0, row_prod_reg};

    assign q_push    = v1_reg && q_ready;
    assign q_data.re = met_pkg::sat_coord(re_sum);
    assign q_data.im = met_pkg::sat_coord(im_sum);

endmodule

[hdl/met_queue.sv]
// ----------------------------------------------------------------------------
// met_queue
// small fifo of points between the front end and the iteration engine
// ----------------------------------------------------------------------------
module met_queue #(
    parameter int DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    output logic            wr_ready,
    input  met_pkg::coord_t wr_data,
    input  logic            rd_en,
    output logic            rd_valid,
    output met_pkg::coord_t rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    met_pkg::coord_t mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign wr_ready = count_reg != CW'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + 1'b1;
            end else if (rd_en && !wr_en) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/met_engine.sv]
// ----------------------------------------------------------------------------
// met_engine
// iterates z = z^2 + c for one point, colors the count, holds the result
// ----------------------------------------------------------------------------
module met_engine #(
    parameter int COORD_FRAC_BITS = 28
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_pop,
    input  met_pkg::coord_t q_data,
    input  logic [15:0]     max_iterations,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [15:0]     m_escape_count,
    output logic [7:0]      m_red,
    output logic [7:0]      m_green,
    output logic [7:0]      m_blue
);

    localparam bit          CAN_ESCAPE = (2 * COORD_FRAC_BITS + 2) < 64;
    localparam logic [63:0] ESC_LIMIT  =
        CAN_ESCAPE ? (64'd1 << (2 * COORD_FRAC_BITS + 2)) : 64'd0;

    met_pkg::eng_state_t state_reg, state_next;

    logic signed [31:0] x_reg, y_reg;
    met_pkg::coord_t    c_reg;
    logic signed [63:0] xx_reg, yy_reg, xy_reg;
    logic [15:0]        iter_reg;
    logic [15:0]        count_reg;
    logic               m_valid_reg;
    logic [15:0]        m_count_reg;
    logic [23:0]        m_rgb_reg;

    logic signed [63:0] xx_prod, yy_prod, xy_prod;
    logic [63:0]        mag;
    logic signed [63:0] diff, re_sum, im_sum;
    logic signed [63:0] c_re_wide, c_im_wide;
    logic signed [31:0] x_new, y_new;
    logic               escaped, finish;
    logic               mult_en, step_en, load_out;

    // squares and cross product of the current z
    assign xx_prod = x_reg * x_reg;
    assign yy_prod = y_reg * y_reg;
    assign xy_prod = x_reg * y_reg;

    // escape test on the registered squares, next z from the same products
    assign mag     = $unsigned(xx_reg) + $unsigned(yy_reg);
    assign escaped = CAN_ESCAPE && (iter_reg != '0) && (mag > ESC_LIMIT);
    assign finish  = escaped || (iter_reg == max_iterations);

    // keep the sums signed so the shifts stay arithmetic
    assign c_re_wide = $signed({{32{c_reg.re[31]}}, c_reg.re});
    assign c_im_wide = $signed({{32{c_reg.im[31]}}, c_reg.im});

    assign diff   = xx_reg - yy_reg;
    assign re_sum = (diff >>> COORD_FRAC_BITS) + c_re_wide;
    assign im_sum = (xy_reg >>> (COORD_FRAC_BITS - 1)) + c_im_wide;
    assign x_new  = met_pkg::sat_coord(re_sum);
    assign y_new  = met_pkg::sat_coord(im_sum);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            met_pkg::ENG_IDLE: begin
                if (q_valid) begin
                    state_next = met_pkg::ENG_MULT;
                end
            end
            met_pkg::ENG_MULT: begin
                state_next = met_pkg::ENG_STEP;
            end
            met_pkg::ENG_STEP: begin
                state_next = finish ? met_pkg::ENG_DONE : met_pkg::ENG_MULT;
            end
            met_pkg::ENG_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = met_pkg::ENG_IDLE;
                end
            end
            default: state_next = met_pkg::ENG_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        q_pop    = 1'b0;
        mult_en  = 1'b0;
        step_en  = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            met_pkg::ENG_IDLE: q_pop    = q_valid;
            met_pkg::ENG_MULT: mult_en  = 1'b1;
            met_pkg::ENG_STEP: step_en  = 1'b1;
            met_pkg::ENG_DONE: load_out = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= met_pkg::ENG_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            x_reg    <= q_data.re;
            y_reg    <= q_data.im;
            c_reg    <= q_data;
            iter_reg <= '0;
        end
        if (mult_en) begin
            xx_reg <= xx_prod;
            yy_reg <= yy_prod;
            xy_reg <= xy_prod;
        end
        if (step_en) begin
            if (finish) begin
                count_reg <= escaped ? iter_reg - 16'd1 : '0;
            end else begin
                x_reg    <= x_new;
                y_reg    <= y_new;
                iter_reg <= iter_reg + 16'd1;
            end
        end
        if (load_out) begin
            m_count_reg <= count_reg;
            m_rgb_reg   <= (count_reg == '0) ? 24'd0 : met_pkg::palette_rgb(count_reg[3:0]);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_escape_count = m_count_reg;
    assign m_red          = m_rgb_reg[23:16];
    assign m_green        = m_rgb_reg[15:8];
    assign m_blue         = m_rgb_reg[7:0];

endmodule

[hdl/mandelbrot_escape_time_pixel.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// escape-time engine: one pixel transaction in, one count and color out
// flow: front end, queue, then multiply/update passes, each a MULT and a STEP state:
//   n+2 passes for escape count n, limit+1 when the point never escapes;
//   the result is then loaded into the output register
// the single iteration engine takes a new pixel only once its result is loaded
// reset: synchronous, active low; clears control, loads register defaults
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel #(
    parameter int COORD_FRAC_BITS = 28
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // pixel transactions
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [9:0]  s_pixel_col,
    input  logic [9:0]  s_pixel_row,
    // result transactions
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_escape_count,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue
);

    // configuration registers
    logic [15:0]        max_iterations_reg;
    logic signed [31:0] origin_real_reg;
    logic signed [31:0] origin_imag_reg;
    logic [30:0]        step_real_reg;
    logic [30:0]        step_imag_reg;

    // front end to queue
    logic            fq_push;
    logic            fq_ready;
    met_pkg::coord_t fq_data;

    // queue to engine
    logic            qe_valid;
    logic            qe_pop;
    met_pkg::coord_t qe_data;

    // writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iterations_reg <= met_pkg::RST_MAX_ITERATIONS;
            origin_real_reg    <= met_pkg::RST_ORIGIN_REAL;
            origin_imag_reg    <= met_pkg::RST_ORIGIN_IMAG;
            step_real_reg      <= met_pkg::RST_STEP_REAL;
            step_imag_reg      <= met_pkg::RST_STEP_IMAG;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                met_pkg::REG_MAX_ITERATIONS: max_iterations_reg <= cfg_data[15:0];
                met_pkg::REG_ORIGIN_REAL:    origin_real_reg    <= cfg_data;
                met_pkg::REG_ORIGIN_IMAG:    origin_imag_reg    <= cfg_data;
                met_pkg::REG_STEP_REAL:      step_real_reg      <= cfg_data[30:0];
                met_pkg::REG_STEP_IMAG:      step_imag_reg      <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // front end: pixel index to point c
    met_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel_col (s_pixel_col),
        .s_pixel_row (s_pixel_row),
        .origin_real (origin_real_reg),
        .origin_imag (origin_imag_reg),
        .step_real   (step_real_reg),
        .step_imag   (step_imag_reg),
        .q_push      (fq_push),
        .q_ready     (fq_ready),
        .q_data      (fq_data)
    );

    // decoupling queue so the front end can keep taking pixels during iteration until the queue fills
    met_queue #(
        .DEPTH (2)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (fq_push),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_en    (qe_pop),
        .rd_valid (qe_valid),
        .rd_data  (qe_data)
    );

    // back end: iteration loop, coloring and output register
    met_engine #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (qe_valid),
        .q_pop          (qe_pop),
        .q_data         (qe_data),
        .max_iterations (max_iterations_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_escape_count (m_escape_count),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue)
    );

endmodule

[hdl/met_checker.sv]
// ----------------------------------------------------------------------------
// met_checker
// port-level checks for the escape-time engine
// ----------------------------------------------------------------------------
module met_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_escape_count,
    input logic [7:0]  m_red,
    input logic [7:0]  m_green,
    input logic [7:0]  m_blue
);

    // pixels taken but not yet delivered
    logic [3:0] pending_reg;
    logic       in_fire, out_fire;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (in_fire && !out_fire) begin
            pending_reg <= pending_reg + 4'd1;
        end else if (out_fire && !in_fire) begin
            pending_reg <= pending_reg - 4'd1;
        end
    end

    // no result left over after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_escape_count) && $stable(m_red)
            && $stable(m_green) && $stable(m_blue))
        else $error("stalled result changed");

    // count zero is always black
    a_zero_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_escape_count == 16'd0 |-> m_red == 8'd0 && m_green == 8'd0
            && m_blue == 8'd0)
        else $error("zero count not black");

    // every result belongs to an accepted pixel
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 4'd0)
        else $error("result without a pending pixel");

endmodule

bind mandelbrot_escape_time_pixel met_checker u_met_checker (.*);
